// ===== rtl/pcsg_pkg.sv =====
// Shared opcodes, status codes and register indexes of the PWM command safety gate.
`timescale 1ns / 1ps
`default_nettype none

package pcsg_pkg;

  // Input opcodes
  localparam logic [1:0] OP_CMD  = 2'd0;
  localparam logic [1:0] OP_ARM  = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_SENT     = 3'd0;
  localparam logic [2:0] ST_DISABLED = 3'd1;
  localparam logic [2:0] ST_BAD      = 3'd2;
  localparam logic [2:0] ST_THR_RNG  = 3'd3;
  localparam logic [2:0] ST_STR_RNG  = 3'd4;
  localparam logic [2:0] ST_ARMSTOP  = 3'd5;
  localparam logic [2:0] ST_WATCHDOG = 3'd6;

  // Configuration register indexes
  localparam logic [2:0] REG_THR_LIM  = 3'd0;
  localparam logic [2:0] REG_STR_LIM  = 3'd1;
  localparam logic [2:0] REG_THR_OFS  = 3'd2;
  localparam logic [2:0] REG_THR_GAIN = 3'd3;
  localparam logic [2:0] REG_STR_OFS  = 3'd4;
  localparam logic [2:0] REG_STR_GAIN = 3'd5;
  localparam logic [2:0] REG_TIMEOUT  = 3'd6;

  // Register reset values
  localparam logic [47:0] THR_LIM_RST  = 48'd6657297614300;
  localparam logic [47:0] STR_LIM_RST  = 48'd7731039438000;
  localparam logic [23:0] THR_OFS_RST  = 24'd0;
  localparam logic [23:0] THR_GAIN_RST = 24'd256;
  localparam logic [23:0] STR_OFS_RST  = 24'd640000;
  localparam logic [23:0] STR_GAIN_RST = 24'd2844;
  localparam logic [15:0] TIMEOUT_RST  = 16'd10;

  // Packed envelope: minimum, neutral, maximum PWM counts
  typedef struct packed {
    logic [15:0] max_pwm;
    logic [15:0] neutral_pwm;
    logic [15:0] min_pwm;
  } pwm_limits_t;

endpackage

`default_nettype wire

// ===== rtl/pwm_command_safety_gate.sv =====
// PWM command safety gate: input register, affine map, envelope check and result register.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------------------
//   in      | input     | in_valid/in_stall   | opcode, throttle_in, steer_in, bad_value, level
//   out     | output    | out_valid/out_stall | thr_pwm, str_pwm, status, watchdog_warning
//   cfg     | input     | cfg_wr_en           | cfg_index, cfg_data (48 bits)
//
// One beat per cycle unless out_stall holds a full result register; a beat passes from the
// input register through the two multipliers, envelope compares and flag update into the
// result register. Beats that produce no result leave nothing behind.
// Reset is synchronous, active low, and clears flags, age and valid bits.
// out_stall holds the result register; the input register then holds too if its beat
// produces a result, and in_stall rises only while both registers are full.
`timescale 1ns / 1ps
`default_nettype none

module pwm_command_safety_gate #(
  parameter int AGE_BITS  = 16,
  parameter int FRAC_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // command channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_opcode,
  input  wire logic signed [31:0] in_throttle_in,
  input  wire logic signed [31:0] in_steer_in,
  input  wire logic               in_bad_value,
  input  wire logic               in_level,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             out_thr_pwm,
  output logic [15:0]             out_str_pwm,
  output logic [2:0]              out_status,
  output logic                    out_watchdog_warning,
  // configuration
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [47:0]        cfg_data
);
  import pcsg_pkg::*;

  localparam int PROD_W = 57;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CMP_W  = (AGE_BITS > 16) ? AGE_BITS : 16;

  // configuration registers
  pwm_limits_t thr_lim_r, str_lim_r;
  logic [23:0] thr_ofs_r, thr_gain_r, str_ofs_r, str_gain_r;
  logic [15:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_lim_r  <= THR_LIM_RST;
      str_lim_r  <= STR_LIM_RST;
      thr_ofs_r  <= THR_OFS_RST;
      thr_gain_r <= THR_GAIN_RST;
      str_ofs_r  <= STR_OFS_RST;
      str_gain_r <= STR_GAIN_RST;
      timeout_r  <= TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_THR_LIM:  thr_lim_r  <= cfg_data;
        REG_STR_LIM:  str_lim_r  <= cfg_data;
        REG_THR_OFS:  thr_ofs_r  <= cfg_data[23:0];
        REG_THR_GAIN: thr_gain_r <= cfg_data[23:0];
        REG_STR_OFS:  str_ofs_r  <= cfg_data[23:0];
        REG_STR_GAIN: str_gain_r <= cfg_data[23:0];
        REG_TIMEOUT:  timeout_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input register
  logic               s1_valid_r;
  logic [1:0]         s1_op_r;
  logic signed [31:0] s1_thr_r, s1_str_r;
  logic               s1_bad_r, s1_level_r;
  logic               s1_adv, s1_emit, out_free;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid_r && (!s1_emit || out_free);
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r    <= in_opcode;
      s1_thr_r   <= in_throttle_in;
      s1_str_r   <= in_steer_in;
      s1_bad_r   <= in_bad_value;
      s1_level_r <= in_level;
    end
  end

  // affine map with floor shift
  logic signed [PROD_W-1:0] t_prod, s_prod, t_shift, s_shift;
  logic signed [SUM_W-1:0]  t_sum, s_sum, t_rnd, s_rnd;
  logic signed [SUM_W-1:0]  t_min, t_max, s_min, s_max;
  logic signed [SUM_W-1:0]  half;

  assign t_prod  = s1_thr_r * $signed({1'b0, thr_gain_r});
  assign s_prod  = s1_str_r * $signed({1'b0, str_gain_r});
  assign t_shift = t_prod >>> FRAC_BITS;
  assign s_shift = s_prod >>> FRAC_BITS;
  assign t_sum   = $signed({{(SUM_W-24){1'b0}}, thr_ofs_r}) + {t_shift[PROD_W-1], t_shift};
  assign s_sum   = $signed({{(SUM_W-24){1'b0}}, str_ofs_r}) - {s_shift[PROD_W-1], s_shift};

  // envelopes scaled to the fraction
  assign t_min = $signed({{(SUM_W-16-FRAC_BITS){1'b0}}, thr_lim_r.min_pwm, {FRAC_BITS{1'b0}}});
  assign t_max = $signed({{(SUM_W-16-FRAC_BITS){1'b0}}, thr_lim_r.max_pwm, {FRAC_BITS{1'b0}}});
  assign s_min = $signed({{(SUM_W-16-FRAC_BITS){1'b0}}, str_lim_r.min_pwm, {FRAC_BITS{1'b0}}});
  assign s_max = $signed({{(SUM_W-16-FRAC_BITS){1'b0}}, str_lim_r.max_pwm, {FRAC_BITS{1'b0}}});

  // round half up
  assign half  = $signed({{(SUM_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}});
  assign t_rnd = t_sum + half;
  assign s_rnd = s_sum + half;

  // gate state
  logic                armed_r, stopped_r, cmd_valid_r, warn_given_r;
  logic [AGE_BITS-1:0] age_r;
  logic                armed_nxt, stopped_nxt, cmd_valid_nxt, warn_given_nxt;
  logic [AGE_BITS-1:0] age_nxt, age_inc;
  logic                enabled, stale;
  logic [15:0]         res_thr, res_str;
  logic [2:0]          res_status;
  logic                res_warn;

  assign enabled = armed_r && !stopped_r;
  assign age_inc = (&age_r) ? age_r : age_r + 1'b1;
  assign stale   = !cmd_valid_r || (CMP_W'(age_inc) > CMP_W'(timeout_r));

  // decide result and next flags
  always_comb begin
    armed_nxt      = armed_r;
    stopped_nxt    = stopped_r;
    cmd_valid_nxt  = cmd_valid_r;
    warn_given_nxt = warn_given_r;
    age_nxt        = age_r;
    s1_emit        = 1'b1;
    res_thr        = thr_lim_r.neutral_pwm;
    res_str        = str_lim_r.neutral_pwm;
    res_status     = ST_DISABLED;
    res_warn       = 1'b0;
    unique case (s1_op_r)
      OP_CMD: begin
        if (!enabled) begin
          res_status = ST_DISABLED;
        end else if (s1_bad_r) begin
          res_status    = ST_BAD;
          cmd_valid_nxt = 1'b0;
        end else if (t_sum < t_min || t_sum > t_max) begin
          res_status    = ST_THR_RNG;
          cmd_valid_nxt = 1'b0;
        end else if (s_sum < s_min || s_sum > s_max) begin
          res_status    = ST_STR_RNG;
          cmd_valid_nxt = 1'b0;
        end else begin
          res_status     = ST_SENT;
          res_thr        = t_rnd[FRAC_BITS +: 16];
          res_str        = s_rnd[FRAC_BITS +: 16];
          age_nxt        = '0;
          cmd_valid_nxt  = 1'b1;
          warn_given_nxt = 1'b0;
        end
      end
      OP_ARM: begin
        if (s1_level_r && stopped_r) begin
          s1_emit = 1'b0;
        end else begin
          armed_nxt      = s1_level_r;
          cmd_valid_nxt  = 1'b0;
          warn_given_nxt = 1'b0;
          res_status     = ST_ARMSTOP;
        end
      end
      OP_STOP: begin
        stopped_nxt    = s1_level_r;
        armed_nxt      = 1'b0;
        cmd_valid_nxt  = 1'b0;
        warn_given_nxt = 1'b0;
        res_status     = ST_ARMSTOP;
      end
      OP_TICK: begin
        age_nxt = age_inc;
        if (!enabled) begin
          res_status = ST_DISABLED;
        end else if (stale) begin
          res_status     = ST_WATCHDOG;
          res_warn       = !warn_given_r;
          warn_given_nxt = 1'b1;
        end else begin
          s1_emit = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // commit state when the beat leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= 1'b0;
      stopped_r    <= 1'b0;
      cmd_valid_r  <= 1'b0;
      warn_given_r <= 1'b0;
      age_r        <= '0;
    end else if (s1_adv) begin
      armed_r      <= armed_nxt;
      stopped_r    <= stopped_nxt;
      cmd_valid_r  <= cmd_valid_nxt;
      warn_given_r <= warn_given_nxt;
      age_r        <= age_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_adv && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_adv && s1_emit) begin
      out_thr_pwm          <= res_thr;
      out_str_pwm          <= res_str;
      out_status           <= res_status;
      out_watchdog_warning <= res_warn;
    end
  end

`ifndef SYNTHESIS
  // a warning only rides on a watchdog neutral
  a_warn_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_watchdog_warning || out_status == ST_WATCHDOG))
    else $error("watchdog warning with non-watchdog status");

  // an estop always leaves the gate disarmed
  a_stop_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> !armed_r)
    else $error("armed while stopped");

  // input stalls only while both registers are full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid && out_stall))
    else $error("input stalled with room downstream");

  // a sent command leaves a fresh valid command behind
  a_sent_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_emit && res_status == ST_SENT && s1_op_r == OP_CMD)
      |=> (cmd_valid_r && age_r == '0 && !warn_given_r))
    else $error("accepted command did not refresh watchdog");
`endif

endmodule

`default_nettype wire

// ===== tb/gate_result_checker.sv =====
// Result checker for the PWM command safety gate: predicts every beat and compares outputs.
`timescale 1ns / 1ps

module gate_result_checker #(
  parameter int AGE_BITS  = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_throttle_in,
  input  logic signed [31:0] in_steer_in,
  input  logic               in_bad_value,
  input  logic               in_level,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        out_thr_pwm,
  input  logic [15:0]        out_str_pwm,
  input  logic [2:0]         out_status,
  input  logic               out_watchdog_warning,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  output int unsigned        errors,
  output int unsigned        pending,
  output int unsigned        checked
);
  import pcsg_pkg::*;

  typedef struct packed {
    logic [15:0] thr_pwm;
    logic [15:0] str_pwm;
    logic [2:0]  status;
    logic        warning;
  } pwm_result_t;

  // Outputs still owed by the gate, oldest first
  pwm_result_t expected_pwm_q[$];

  // Register copies
  pwm_limits_t thr_env, str_env;
  logic [23:0] thr_ofs, thr_gain, str_ofs, str_gain;
  logic [15:0] timeout_ticks;

  // Gate flags
  logic                armed, stopped, cmd_valid, warned;
  logic [AGE_BITS-1:0] cmd_age;

  int unsigned fail_count = 0;
  int unsigned result_count = 0;
  int unsigned shown = 0;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (shown < 100) begin
      shown++;
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  // Append one owed result at the tail
  function automatic void queue_expected(input pwm_result_t r);
    expected_pwm_q.insert(expected_pwm_q.size(), r);
  endfunction

  function automatic pwm_result_t neutral_result(input logic [2:0] st, input logic warn);
    pwm_result_t r;
    r.thr_pwm = thr_env.neutral_pwm;
    r.str_pwm = str_env.neutral_pwm;
    r.status  = st;
    r.warning = warn;
    return r;
  endfunction

  // Work out what one accepted beat does to the flags and what it sends
  task automatic predict_gate_beat(input logic [1:0] op, input logic signed [31:0] thr_in,
                                   input logic signed [31:0] str_in, input logic bad,
                                   input logic lvl);
    longint signed thr_q, str_q;
    logic          stale;
    pwm_result_t   r;
    case (op)
      OP_CMD: begin
        if (!armed || stopped) begin
          queue_expected(neutral_result(ST_DISABLED, 1'b0));
        end else if (bad) begin
          cmd_valid = 1'b0;
          queue_expected(neutral_result(ST_BAD, 1'b0));
        end else begin
          // affine map with floor shift of the Q.2F product
          thr_q = longint'(thr_ofs)
                  + ((longint'(thr_in) * longint'(thr_gain)) >>> FRAC_BITS);
          str_q = longint'(str_ofs)
                  - ((longint'(str_in) * longint'(str_gain)) >>> FRAC_BITS);
          if (thr_q < (longint'(thr_env.min_pwm) <<< FRAC_BITS) ||
              thr_q > (longint'(thr_env.max_pwm) <<< FRAC_BITS)) begin
            cmd_valid = 1'b0;
            queue_expected(neutral_result(ST_THR_RNG, 1'b0));
          end else if (str_q < (longint'(str_env.min_pwm) <<< FRAC_BITS) ||
                       str_q > (longint'(str_env.max_pwm) <<< FRAC_BITS)) begin
            cmd_valid = 1'b0;
            queue_expected(neutral_result(ST_STR_RNG, 1'b0));
          end else begin
            // round half up to whole counts
            thr_q = (thr_q + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            str_q = (str_q + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            cmd_age   = '0;
            cmd_valid = 1'b1;
            warned    = 1'b0;
            r.thr_pwm = 16'(thr_q);
            r.str_pwm = 16'(str_q);
            r.status  = ST_SENT;
            r.warning = 1'b0;
            queue_expected(r);
          end
        end
      end
      OP_ARM: begin
        // drop an arm request while stopped
        if (!(lvl && stopped)) begin
          armed     = lvl;
          cmd_valid = 1'b0;
          warned    = 1'b0;
          queue_expected(neutral_result(ST_ARMSTOP, 1'b0));
        end
      end
      OP_STOP: begin
        stopped   = lvl;
        armed     = 1'b0;
        cmd_valid = 1'b0;
        warned    = 1'b0;
        queue_expected(neutral_result(ST_ARMSTOP, 1'b0));
      end
      default: begin
        // advance the saturating age, then decide on the watchdog
        if (cmd_age != '1) cmd_age++;
        stale = !cmd_valid || (cmd_age > timeout_ticks);
        if (!armed || stopped) begin
          queue_expected(neutral_result(ST_DISABLED, 1'b0));
        end else if (stale) begin
          queue_expected(neutral_result(ST_WATCHDOG, !warned));
          warned = 1'b1;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    pwm_result_t want;
    if (!rst_n) begin
      expected_pwm_q.delete();
      thr_env       = THR_LIM_RST;
      str_env       = STR_LIM_RST;
      thr_ofs       = THR_OFS_RST;
      thr_gain      = THR_GAIN_RST;
      str_ofs       = STR_OFS_RST;
      str_gain      = STR_GAIN_RST;
      timeout_ticks = TIMEOUT_RST;
      armed         = 1'b0;
      stopped       = 1'b0;
      cmd_valid     = 1'b0;
      warned        = 1'b0;
      cmd_age       = '0;
    end else begin
      // compare an output beat with the oldest expectation
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_pwm_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: status %0d", out_status));
        end else begin
          want = expected_pwm_q.pop_front();
          if (out_thr_pwm !== want.thr_pwm)
            report_mismatch($sformatf("throttle got %0d expected %0d",
                                      out_thr_pwm, want.thr_pwm));
          if (out_str_pwm !== want.str_pwm)
            report_mismatch($sformatf("steering got %0d expected %0d",
                                      out_str_pwm, want.str_pwm));
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_status, want.status));
          if (out_watchdog_warning !== want.warning)
            report_mismatch($sformatf("watchdog_warning got %0b expected %0b",
                                      out_watchdog_warning, want.warning));
        end
      end
      // track register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_THR_LIM:  thr_env = cfg_data;
          REG_STR_LIM:  str_env = cfg_data;
          REG_THR_OFS:  thr_ofs = cfg_data[23:0];
          REG_THR_GAIN: thr_gain = cfg_data[23:0];
          REG_STR_OFS:  str_ofs = cfg_data[23:0];
          REG_STR_GAIN: str_gain = cfg_data[23:0];
          REG_TIMEOUT:  timeout_ticks = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_gate_beat(in_opcode, in_throttle_in, in_steer_in, in_bad_value, in_level);
    end
    pending <= expected_pwm_q.size();
    errors  <= fail_count;
    checked <= result_count;
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the PWM command safety gate: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import pcsg_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned RANDOM_PHASES   = 9;
  localparam int unsigned BEATS_PER_PHASE = 215;
  localparam int          FRAC_BITS       = 8;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_opcode = OP_TICK;
  logic signed [31:0] in_throttle_in = '0;
  logic signed [31:0] in_steer_in = '0;
  logic               in_bad_value = 1'b0;
  logic               in_level = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        out_thr_pwm;
  logic [15:0]        out_str_pwm;
  logic [2:0]         out_status;
  logic               out_watchdog_warning;
  logic               cfg_wr_en = 1'b0;
  logic [2:0]         cfg_index = REG_THR_LIM;
  logic [47:0]        cfg_data = '0;

  int unsigned errors, pending, checked;
  int unsigned cycles = 0;
  int unsigned beats_sent = 0;

  // idling control
  logic        quiet = 1'b0;
  int unsigned gap_odds = 2;
  int unsigned stall_odds = 2;
  int unsigned stall_left = 0;

  // register values in force, used to aim commands at the envelope
  pwm_limits_t thr_env, str_env;
  logic [23:0] thr_ofs, thr_gain, str_ofs, str_gain;
  logic [15:0] timeout_ticks;

  pwm_command_safety_gate dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_throttle_in       (in_throttle_in),
    .in_steer_in          (in_steer_in),
    .in_bad_value         (in_bad_value),
    .in_level             (in_level),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_thr_pwm          (out_thr_pwm),
    .out_str_pwm          (out_str_pwm),
    .out_status           (out_status),
    .out_watchdog_warning (out_watchdog_warning),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  gate_result_checker result_chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_throttle_in       (in_throttle_in),
    .in_steer_in          (in_steer_in),
    .in_bad_value         (in_bad_value),
    .in_level             (in_level),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_thr_pwm          (out_thr_pwm),
    .out_str_pwm          (out_str_pwm),
    .out_status           (out_status),
    .out_watchdog_warning (out_watchdog_warning),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .errors               (errors),
    .pending              (pending),
    .checked              (checked)
  );

  always #1 clk = ~clk;

  // Watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Output stall in bursts of random length
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_odds != 0 && $urandom_range(0, 9) < stall_odds) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Present one beat, with an optional idle burst first, and hold it until taken
  task automatic send_beat(input logic [1:0] op, input logic signed [31:0] thr,
                           input logic signed [31:0] str, input logic bad, input logic lvl);
    if (!quiet && gap_odds != 0 && $urandom_range(0, 9) < gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_throttle_in <= thr;
    in_steer_in    <= str;
    in_bad_value   <= bad;
    in_level       <= lvl;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // Drop valid and wait until every owed result is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [47:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_config();
    put_reg(REG_THR_LIM, thr_env);
    put_reg(REG_STR_LIM, str_env);
    put_reg(REG_THR_OFS, {24'd0, thr_ofs});
    put_reg(REG_THR_GAIN, {24'd0, thr_gain});
    put_reg(REG_STR_OFS, {24'd0, str_ofs});
    put_reg(REG_STR_GAIN, {24'd0, str_gain});
    put_reg(REG_TIMEOUT, {32'd0, timeout_ticks});
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [31:0] clamp32(input longint signed v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  // Mostly aim near the envelope edges so commands pass and fail by small margins
  function automatic logic signed [31:0] pick_input(input pwm_limits_t env,
                                                    input logic [23:0] ofs,
                                                    input logic [23:0] gain,
                                                    input logic negate);
    longint signed lo, hi, target, span;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2:    return clamp32(longint'($urandom_range(0, 4000)) - 2000);
      default: begin
        lo = (env.min_pwm < env.max_pwm) ? longint'(env.min_pwm) : longint'(env.max_pwm);
        hi = (env.min_pwm < env.max_pwm) ? longint'(env.max_pwm) : longint'(env.min_pwm);
        lo = (lo > 3) ? lo - 3 : 0;
        hi = hi + 3;
        target = (longint'($urandom_range(32'(hi), 32'(lo))) <<< FRAC_BITS)
                 + longint'($urandom_range(0, 255));
        span = negate ? longint'(ofs) - target : target - longint'(ofs);
        return clamp32((span <<< FRAC_BITS) / longint'(gain)
                       + longint'($urandom_range(0, 4)) - 2);
      end
    endcase
  endfunction

  function automatic pwm_limits_t random_env();
    pwm_limits_t env;
    env.min_pwm     = 16'($urandom_range(0, 60000));
    env.max_pwm     = 16'(32'(env.min_pwm) + $urandom_range(0, 5000));
    env.neutral_pwm = 16'($urandom);
    return env;
  endfunction

  function automatic logic [23:0] center_offset(input pwm_limits_t env);
    logic [16:0] mid;
    mid = (17'(env.min_pwm) + 17'(env.max_pwm)) >> 1;
    return {mid[15:0], 8'($urandom)};
  endfunction

  // Register setting for each phase: reset values, extremes, inverted envelopes, random
  task automatic pick_config(input int unsigned ph);
    thr_env       = random_env();
    str_env       = random_env();
    thr_ofs       = center_offset(thr_env);
    str_ofs       = center_offset(str_env);
    thr_gain      = 24'($urandom_range(1, 8192));
    str_gain      = 24'($urandom_range(1, 8192));
    timeout_ticks = 16'($urandom_range(1, 24));
    case (ph)
      0: begin
        thr_env       = THR_LIM_RST;
        str_env       = STR_LIM_RST;
        thr_ofs       = THR_OFS_RST;
        thr_gain      = THR_GAIN_RST;
        str_ofs       = STR_OFS_RST;
        str_gain      = STR_GAIN_RST;
        timeout_ticks = TIMEOUT_RST;
      end
      1: begin
        thr_env       = {16'hffff, 16'($urandom), 16'h0000};
        str_env       = {16'hffff, 16'($urandom), 16'h0000};
        thr_ofs       = '0;
        str_ofs       = '0;
        thr_gain      = 24'd1;
        str_gain      = 24'd1;
        timeout_ticks = 16'd1;
      end
      2: begin
        thr_ofs       = 24'hffffff;
        str_ofs       = 24'hffffff;
        thr_gain      = 24'hffffff;
        str_gain      = 24'hffffff;
        timeout_ticks = 16'hffff;
      end
      3: begin
        // min above max: every enabled command without a bad value fails the throttle check
        thr_env.min_pwm = 16'($urandom_range(200, 60000));
        thr_env.max_pwm = thr_env.min_pwm - 16'($urandom_range(1, 100));
        timeout_ticks   = 16'd3;
      end
      4: begin
        str_env.min_pwm = 16'($urandom_range(200, 60000));
        str_env.max_pwm = str_env.min_pwm - 16'($urandom_range(1, 100));
        timeout_ticks   = 16'd2;
      end
      default: ;
    endcase
  endtask

  // Mostly armed command traffic with tick runs, plus arm, estop and recovery
  task automatic random_phase(input int unsigned beats);
    int unsigned stop_at, run;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      case ($urandom_range(0, 19))
        0: send_beat(OP_ARM, $urandom, $urandom, 1'($urandom), $urandom_range(0, 9) < 8);
        1: send_beat(OP_STOP, $urandom, $urandom, 1'($urandom), $urandom_range(0, 9) < 3);
        2: begin
          send_beat(OP_STOP, $urandom, $urandom, 1'($urandom), 1'b0);
          send_beat(OP_ARM, $urandom, $urandom, 1'($urandom), 1'b1);
        end
        3, 4: begin
          run = $urandom_range(1, (timeout_ticks < 40) ? int'(timeout_ticks) + 3 : 40);
          repeat (run) send_beat(OP_TICK, $urandom, $urandom, 1'($urandom), 1'($urandom));
        end
        5, 6, 7: send_beat(OP_TICK, $urandom, $urandom, 1'($urandom), 1'($urandom));
        default: send_beat(OP_CMD, pick_input(thr_env, thr_ofs, thr_gain, 1'b0),
                           pick_input(str_env, str_ofs, str_gain, 1'b1),
                           $urandom_range(0, 19) == 0, 1'($urandom));
      endcase
    end
  endtask

  initial begin
    int unsigned ph;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed cases under reset register values
    send_beat(OP_CMD, '0, '0, 1'b0, 1'b0);                       // disarmed command
    send_beat(OP_TICK, '0, '0, 1'b0, 1'b0);                      // disarmed tick
    send_beat(OP_ARM, '0, '0, 1'b0, 1'b1);
    send_beat(OP_TICK, '0, '0, 1'b0, 1'b0);                      // stale, warning
    send_beat(OP_TICK, '0, '0, 1'b0, 1'b0);                      // stale, no warning
    send_beat(OP_CMD, 32'sd384000, 32'sd16384, 1'b1, 1'b0);      // bad value
    send_beat(OP_CMD, 32'sd384000, 32'sd16384, 1'b0, 1'b0);      // sent
    send_beat(OP_CMD, 32'sd384128, 32'sd16384, 1'b0, 1'b1);      // exact half rounds up
    send_beat(OP_CMD, 32'sd396800, 32'sd16384, 1'b0, 1'b0);      // throttle at maximum
    send_beat(OP_CMD, 32'sd396801, 32'sd16384, 1'b0, 1'b0);      // just above maximum
    send_beat(OP_CMD, 32'sh7fffffff, 32'sd16384, 1'b0, 1'b0);
    send_beat(OP_CMD, 32'sh80000000, 32'sd16384, 1'b0, 1'b0);
    send_beat(OP_CMD, 32'sd384000, 32'sh80000000, 1'b0, 1'b0);   // steering out of range
    send_beat(OP_CMD, 32'sd384000, 32'sh7fffffff, 1'b0, 1'b0);
    send_beat(OP_CMD, 32'sh7fffffff, 32'sh80000000, 1'b0, 1'b0); // throttle checked first
    send_beat(OP_TICK, 32'sh7fffffff, 32'sh7fffffff, 1'b1, 1'b1);
    send_beat(OP_STOP, '0, '0, 1'b0, 1'b1);
    send_beat(OP_CMD, 32'sd384000, 32'sd16384, 1'b0, 1'b0);      // stopped command
    send_beat(OP_ARM, '0, '0, 1'b0, 1'b1);                       // arm while stopped
    send_beat(OP_ARM, '0, '0, 1'b0, 1'b0);                       // disarm while stopped
    send_beat(OP_TICK, '0, '0, 1'b0, 1'b0);
    send_beat(OP_STOP, '0, '0, 1'b0, 1'b0);
    send_beat(OP_ARM, '0, '0, 1'b0, 1'b1);
    send_beat(OP_CMD, 32'sd384000, 32'sd16384, 1'b0, 1'b1);
    send_beat(OP_ARM, '0, '0, 1'b0, 1'b0);

    // random phases, each with its own register setting and idling mix
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      if (ph == RANDOM_PHASES - 1) quiet <= 1'b1;
      pick_config(ph);
      gap_odds = (ph % 3 == 1) ? 0 : $urandom_range(1, 4);
      stall_odds <= (ph % 3 == 2) ? 0 : $urandom_range(1, 4);
      load_config();
      random_phase(BEATS_PER_PHASE);
    end
    settle();

    $display("covered %0d beats: directed cases and %0d register settings",
             beats_sent, RANDOM_PHASES);
    $display("%0d results checked, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pcsg_pkg.sv
rtl/pwm_command_safety_gate.sv
tb/gate_result_checker.sv
tb/tb.sv
